### hw/rtl/chm_pkg.sv
// Shared types, codes and the key mixing function of the chained hash map engine.
// No dependencies.
`default_nettype none
package chm_pkg;
   localparam int unsigned DefTableDepth = 1024;
   localparam int unsigned CfgW = 11;
   localparam int unsigned KeyW = 32;
   localparam int unsigned ValW = 32;

   typedef enum logic [1:0] {
      OP_INSERT = 2'd0,
      OP_SEARCH = 2'd1,
      OP_REMOVE = 2'd2,
      OP_NONE   = 2'd3
   } op_type;

   typedef enum logic [2:0] {
      ST_OK       = 3'd0,
      ST_LOAD     = 3'd1,
      ST_DUP      = 3'd2,
      ST_FULL     = 3'd3,
      ST_NOTFOUND = 3'd4
   } status_type;

   typedef enum logic [0:0] {
      REG_PRIMARY = 1'b0,
      REG_USED    = 1'b1
   } reg_type;

   // start/result handshake of the remainder unit
   typedef struct packed {
      logic            start;
      logic [31:0]     dividend;
      logic [CfgW-1:0] divisor;
   } mod_req_type;

   typedef struct packed {
      logic            done;
      logic [CfgW-1:0] rem;
   } mod_rsp_type;

   function automatic logic [31:0] mix_key(input logic [31:0] k);
      logic [31:0] i;
      i = k;
      i = i + ~(i << 9);
      i = i ^ {i[13:0], i[31:14]};
      i = i + (i << 4);
      i = i ^ {i[9:0], i[31:10]};
      return i;
   endfunction
endpackage
`default_nettype wire

### hw/rtl/chm_ram.sv
// Generic simple dual-port RAM, one write port, one read port, registered read.
// No dependencies.
`default_nettype none
module chm_ram #(
   parameter int unsigned WIDTH = 8,
   parameter int unsigned DEPTH = 16
) (
   input  wire logic                     clock,
   input  wire logic                     we,
   input  wire logic [$clog2(DEPTH)-1:0] waddr,
   input  wire logic [WIDTH-1:0]         wdata,
   input  wire logic [$clog2(DEPTH)-1:0] raddr,
   output      logic [WIDTH-1:0]         rdata
);
   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rdata <= mem[raddr];
   end
endmodule
`default_nettype wire

### hw/rtl/chm_mod.sv
// Bit-serial remainder unit: 32-bit dividend modulo an 11-bit divisor.
// Depends on chm_pkg.
`default_nettype none
module chm_mod import chm_pkg::*; (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire mod_req_type req,
   output      mod_rsp_type rsp
);
   logic            busy_ff, busy_in;
   logic [4:0]      cnt_ff, cnt_in;
   logic [31:0]     dvd_ff, dvd_in;
   logic [CfgW:0]   rem_ff, rem_in;
   logic [CfgW-1:0] div_ff, div_in;
   logic [CfgW:0]   trial;

   always_comb begin
      trial   = {rem_ff[CfgW-1:0], dvd_ff[31]};
      busy_in = busy_ff;
      cnt_in  = cnt_ff;
      dvd_in  = dvd_ff;
      rem_in  = rem_ff;
      div_in  = div_ff;
      if (req.start) begin
         busy_in = 1'b1;
         cnt_in  = '0;
         dvd_in  = req.dividend;
         rem_in  = '0;
         div_in  = req.divisor;
      end else if (busy_ff) begin
         rem_in = (trial >= {1'b0, div_ff}) ? trial - {1'b0, div_ff} : trial;
         dvd_in = {dvd_ff[30:0], 1'b0};
         cnt_in = cnt_ff + 5'd1;
         if (cnt_ff == 5'd31) busy_in = 1'b0;
      end
   end

   assign rsp.done = busy_ff && (cnt_ff == 5'd31) && !req.start;
   assign rsp.rem  = rem_in[CfgW-1:0];

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         cnt_ff  <= cnt_in;
      end
      dvd_ff <= dvd_in;
      rem_ff <= rem_in;
      div_ff <= div_in;
   end
endmodule
`default_nettype wire

### hw/rtl/chained_hash_map_engine.sv
// Chained hash map engine top level: request sequencer around one slot RAM.
// Depends on chm_pkg, chm_ram, chm_mod.
//
// Usage:
//  - req_ channel: one word per request; req_tuser carries the request type
//    (insert, search, remove), req_tdata carries key and value.
//  - rsp_ channel: exactly one word per request with status, value and the
//    live entry count after the request.
//  - csr_ channel: writes primary_size (index 0) or used_size (index 1);
//    always ready, only to be used while the engine is idle.
//  - One request at a time. The hash is combinational; after acceptance the
//    remainder unit runs, then each chain slot is visited in turn, then, when
//    an insert must append, the overflow slots are scanned and the new slot is
//    filled. The load limit and the unknown request type answer in the cycle
//    after acceptance; overflow full is only known after the walk and, if the
//    overflow region is not empty, the scan. After the response word is taken
//    the engine returns to idle before it takes the next request.
//    The remainder unit and the single RAM read port set this timing.
//  - Reset: every slot of the RAM is swept to zero in turn; req_tready
//    stays low meanwhile. Register writes are taken during the sweep.
//  - When the receiver stalls, the response word holds on rsp_ and no new
//    request is accepted until it is taken.
`default_nettype none
module chained_hash_map_engine import chm_pkg::*; #(
   parameter int unsigned TABLE_DEPTH = DefTableDepth
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output      logic        req_tready,
   input  wire logic [63:0] req_tdata,   // key[31:0], value_in[63:32]
   input  wire logic [1:0]  req_tuser,   // req_type[1:0]
   output      logic        rsp_tvalid,
   input  wire logic        rsp_tready,
   output      logic [47:0] rsp_tdata,   // status[2:0], value_out[34:3],
                                         // entry_count[45:35], zero[47:46]
   input  wire logic        csr_valid,
   output      logic        csr_ready,
   input  wire logic [0:0]  csr_index,
   input  wire logic [10:0] csr_data
);
   localparam int unsigned IW   = $clog2(TABLE_DEPTH);
   localparam int unsigned W    = 1 + IW + KeyW + ValW;
   localparam int unsigned VLo  = 0;
   localparam int unsigned KLo  = ValW;
   localparam int unsigned LLo  = ValW + KeyW;
   localparam int unsigned UBit = ValW + KeyW + IW;

   typedef enum logic [6:0] {
      S_CLEAR = 7'b0000001,
      S_IDLE  = 7'b0000010,
      S_MOD   = 7'b0000100,
      S_LOOK  = 7'b0001000,
      S_SCAN  = 7'b0010000,
      S_FILL  = 7'b0100000,
      S_RESP  = 7'b1000000
   } state_type;

   state_type       state_ff, state_in;
   logic [CfgW-1:0] prim_ff, prim_in, used_ff, used_in;
   op_type          op_ff, op_in;
   logic [31:0]     key_ff, key_in, val_ff, val_in;
   logic [CfgW-1:0] p_ff, p_in, u_ff, u_in;
   logic [IW-1:0]   node_ff, node_in, scan_ff, scan_in, tail_ff, tail_in, clr_ff, clr_in;
   logic            ffv_ff, ffv_in;
   logic [IW-1:0]   ff_ff, ff_in, ffl_ff, ffl_in;
   logic [KeyW-1:0] tkey_ff, tkey_in;
   logic [ValW-1:0] tval_ff, tval_in;
   status_type      status_ff, status_in;
   logic [31:0]     vout_ff, vout_in;
   logic [CfgW-1:0] count_ff, count_in;

   logic [31:0]     eff_p32, eff_u32, nxt32;
   logic            we;
   logic [IW-1:0]   waddr, raddr;
   logic [W-1:0]    wdata, rdata;
   logic            r_used, hit;
   logic [IW-1:0]   r_link;
   logic [KeyW-1:0] r_key;
   logic [ValW-1:0] r_val;
   mod_req_type     mreq;
   mod_rsp_type     mrsp;

   assign r_used = rdata[UBit];
   assign r_link = rdata[LLo +: IW];
   assign r_key  = rdata[KLo +: KeyW];
   assign r_val  = rdata[VLo +: ValW];
   assign hit    = r_used && (r_key == key_ff);

   assign csr_ready  = 1'b1;
   assign req_tready = (state_ff == S_IDLE);
   assign rsp_tvalid = (state_ff == S_RESP);
   assign rsp_tdata  = {2'b00, count_ff, vout_ff, status_ff};

   // effective register values: primary 0 acts as 1, both capped at table depth
   always_comb begin
      eff_p32 = (prim_ff == '0) ? 32'd1 : {21'd0, prim_ff};
      if (eff_p32 > TABLE_DEPTH) eff_p32 = TABLE_DEPTH;
      eff_u32 = {21'd0, used_ff};
      if (eff_u32 > TABLE_DEPTH) eff_u32 = TABLE_DEPTH;
   end

   chm_mod u_mod (.clock(clock), .reset(reset), .req(mreq), .rsp(mrsp));

   chm_ram #(.WIDTH(W), .DEPTH(TABLE_DEPTH)) u_slots (
      .clock(clock), .we(we), .waddr(waddr), .wdata(wdata),
      .raddr(raddr), .rdata(rdata)
   );

   always_comb begin
      state_in  = state_ff;
      prim_in   = prim_ff;
      used_in   = used_ff;
      op_in     = op_ff;
      key_in    = key_ff;
      val_in    = val_ff;
      p_in      = p_ff;
      u_in      = u_ff;
      node_in   = node_ff;
      scan_in   = scan_ff;
      tail_in   = tail_ff;
      clr_in    = clr_ff;
      ffv_in    = ffv_ff;
      ff_in     = ff_ff;
      ffl_in    = ffl_ff;
      tkey_in   = tkey_ff;
      tval_in   = tval_ff;
      status_in = status_ff;
      vout_in   = vout_ff;
      count_in  = count_ff;
      we        = 1'b0;
      waddr     = node_ff;
      wdata     = '0;
      raddr     = node_ff;
      nxt32     = 32'({1'b0, scan_ff}) + 32'd1;
      mreq.start    = 1'b0;
      mreq.dividend = mix_key(req_tdata[31:0]);
      mreq.divisor  = eff_p32[CfgW-1:0];

      if (csr_valid) begin
         unique case (reg_type'(csr_index))
            REG_PRIMARY: prim_in = csr_data;
            REG_USED:    used_in = csr_data;
            default:     prim_in = prim_ff;
         endcase
      end

      unique case (state_ff)
         S_CLEAR: begin
            we     = 1'b1;
            waddr  = clr_ff;
            clr_in = clr_ff + 1'b1;
            if (32'(clr_ff) == TABLE_DEPTH - 1) state_in = S_IDLE;
         end
         S_IDLE: begin
            if (req_tvalid) begin
               op_in     = op_type'(req_tuser);
               key_in    = req_tdata[31:0];
               val_in    = req_tdata[63:32];
               p_in      = eff_p32[CfgW-1:0];
               u_in      = eff_u32[CfgW-1:0];
               ffv_in    = 1'b0;
               status_in = ST_OK;
               vout_in   = '0;
               priority if (op_type'(req_tuser) == OP_NONE) begin
                  state_in = S_RESP;
               end else if (op_type'(req_tuser) == OP_INSERT &&
                            32'(count_ff) + 32'd1 > eff_p32) begin
                  status_in = ST_LOAD;
                  state_in  = S_RESP;
               end else begin
                  mreq.start = 1'b1;
                  state_in   = S_MOD;
               end
            end
         end
         S_MOD: begin
            if (mrsp.done) begin
               node_in  = IW'(mrsp.rem);
               raddr    = IW'(mrsp.rem);
               state_in = S_LOOK;
            end
         end
         S_LOOK: begin
            if (hit) begin
               state_in = S_RESP;
               if (op_ff == OP_INSERT) begin
                  status_in = ST_DUP;
               end else begin
                  vout_in = r_val;
                  if (op_ff == OP_REMOVE) begin
                     we    = 1'b1;
                     waddr = node_ff;
                     wdata = {1'b0, r_link, r_key, r_val};
                     if (count_ff != '0) count_in = count_ff - 1'b1;
                  end
               end
            end else begin
               if (!r_used && !ffv_ff) begin
                  ffv_in = 1'b1;
                  ff_in  = node_ff;
                  ffl_in = r_link;
               end
               if (r_link != '0) begin
                  node_in = r_link;
                  raddr   = r_link;
               end else if (op_ff != OP_INSERT) begin
                  status_in = ST_NOTFOUND;
                  state_in  = S_RESP;
               end else if (ffv_ff || !r_used) begin
                  we        = 1'b1;
                  waddr     = ffv_ff ? ff_ff : node_ff;
                  wdata     = {1'b1, (ffv_ff ? ffl_ff : r_link), key_ff, val_ff};
                  count_in  = count_ff + 1'b1;
                  state_in  = S_RESP;
               end else begin
                  tail_in = node_ff;
                  tkey_in = r_key;
                  tval_in = r_val;
                  if (p_ff < u_ff) begin
                     scan_in  = IW'(p_ff);
                     raddr    = IW'(p_ff);
                     state_in = S_SCAN;
                  end else begin
                     status_in = ST_FULL;
                     state_in  = S_RESP;
                  end
               end
            end
         end
         S_SCAN: begin
            if (!r_used && r_link == '0) begin
               // link the free overflow slot behind the chain tail
               we       = 1'b1;
               waddr    = tail_ff;
               wdata    = {1'b1, scan_ff, tkey_ff, tval_ff};
               state_in = S_FILL;
            end else if (nxt32 >= 32'(u_ff)) begin
               status_in = ST_FULL;
               state_in  = S_RESP;
            end else begin
               scan_in = IW'(nxt32);
               raddr   = IW'(nxt32);
            end
         end
         S_FILL: begin
            we       = 1'b1;
            waddr    = scan_ff;
            wdata    = {1'b1, {IW{1'b0}}, key_ff, val_ff};
            count_in = count_ff + 1'b1;
            state_in = S_RESP;
         end
         S_RESP: begin
            if (rsp_tready) state_in = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_CLEAR;
         prim_ff  <= CfgW'(512);
         used_ff  <= CfgW'(1024);
         clr_ff   <= '0;
         count_ff <= '0;
         ffv_ff   <= 1'b0;
      end else begin
         state_ff <= state_in;
         prim_ff  <= prim_in;
         used_ff  <= used_in;
         clr_ff   <= clr_in;
         count_ff <= count_in;
         ffv_ff   <= ffv_in;
      end
      op_ff     <= op_in;
      key_ff    <= key_in;
      val_ff    <= val_in;
      p_ff      <= p_in;
      u_ff      <= u_in;
      node_ff   <= node_in;
      scan_ff   <= scan_in;
      tail_ff   <= tail_in;
      ff_ff     <= ff_in;
      ffl_ff    <= ffl_in;
      tkey_ff   <= tkey_in;
      tval_ff   <= tval_in;
      status_ff <= status_in;
      vout_ff   <= vout_in;
   end

   a_no_overlap: assert property (@(posedge clock) disable iff (reset)
      !(req_tready && rsp_tvalid)) else $error("request taken while response pending");
   a_count_cap: assert property (@(posedge clock) disable iff (reset)
      32'(count_ff) <= TABLE_DEPTH) else $error("entry count above table depth");
   a_mod_done: assert property (@(posedge clock) disable iff (reset)
      mrsp.done |-> state_ff == S_MOD) else $error("remainder done outside hash phase");
   a_count_step: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_IDLE || state_ff == S_RESP) |=> $stable(count_ff) || $past(req_tvalid))
      else $error("entry count changed without a request");
endmodule
`default_nettype wire
